>>> rtl/file_block_cache_lookup_macros.svh
// ---------------------------------------------------------------------------
// file_block_cache_lookup_macros.svh
// Assertion macros shared by the file block cache RTL.
// ---------------------------------------------------------------------------
`ifndef FILE_BLOCK_CACHE_LOOKUP_MACROS_SVH
`define FILE_BLOCK_CACHE_LOOKUP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FBCL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FBCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fbcl_pkg.sv
// ---------------------------------------------------------------------------
// fbcl_pkg
// Types, widths and codes of the file block cache lookup.
// ---------------------------------------------------------------------------
package fbcl_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int BLOCK_BYTES    = 4096;
  localparam int NUM_FILES      = 8;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FILE_W   = 3;
  localparam int ADDR_W   = 31;
  localparam int OFFSET_W = 16;
  localparam int FILL_W   = $clog2(BLOCK_BYTES) + 1;
  localparam int AGE_W    = 32;
  localparam int CFG_W    = 16;

  localparam logic [CFG_W-1:0] PINNED_LENGTH_RST = CFG_W'(4608);
  localparam logic [AGE_W-1:0] AGE_RST           = AGE_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP  = 2'd0,
    OP_PRELOAD = 2'd1,
    OP_INVAL   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_HIT   = 2'd0,
    STS_MISS  = 2'd1,
    STS_NOBLK = 2'd2,
    STS_DONE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_COMMIT
  } state_t;

  // one stored cache entry (valid bits live in flops outside the RAM)
  typedef struct packed {
    logic [FILE_W-1:0] file;
    logic [ADDR_W-1:0] start;
    logic [FILL_W-1:0] length;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

>>> rtl/file_block_cache_lookup.sv
// ---------------------------------------------------------------------------
// file_block_cache_lookup
// Fully associative cache of file blocks with a pinned entry zero.
// ---------------------------------------------------------------------------
// Usage:
//   An item (in_op, in_file_id, in_address, in_file_size) is taken at a
//   clock edge with start high and busy low. Ops: lookup, preload, invalidate.
//   Exactly one result per item appears on the out_ ports for one cycle,
//   flagged by out_valid; the receiver cannot stall it, so it must sample then.
//   cfg_wr_en/cfg_wr_data write the pinned length of entry zero; write it
//   only while busy is low.
// Timing:
//   The entry table is one RAM read one entry per cycle, so each item walks
//   entries 1..NUM_BLOCKS-1 while busy stays high, and out_valid is high in
//   the first cycle with busy low again. A new item can be taken in that same
//   cycle; no new item is taken while the block is still busy with the last.
// Reset:
//   Synchronous, rst_n low. Only entry zero is valid, the fill age counter
//   restarts at one and the pinned length returns to 4608. Unwritten RAM
//   words are masked by their clear valid bits, so no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "file_block_cache_lookup_macros.svh"

module file_block_cache_lookup
  import fbcl_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [OP_W-1:0]               in_op,
  input  logic [FILE_W-1:0]             in_file_id,
  input  logic [ADDR_W-1:0]             in_address,
  input  logic [ADDR_W-1:0]             in_file_size,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  output logic                          out_valid,
  output logic [STATUS_W-1:0]           out_status,
  output logic [$clog2(NUM_BLOCKS)-1:0] out_block_index,
  output logic [OFFSET_W-1:0]           out_offset,
  output logic [ADDR_W-1:0]             out_fetch_address,
  output logic [FILL_W-1:0]             out_fill_length
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  fbcl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fbcl_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_file_id        (in_file_id),
    .in_address        (in_address),
    .in_file_size      (in_file_size),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_block_index   (out_block_index),
    .out_offset        (out_offset),
    .out_fetch_address (out_fetch_address),
    .out_fill_length   (out_fill_length)
  );

  `FBCL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted but block not busy")
  `FBCL_ASSERT_SAME(a_result_idle, out_valid, !busy, "result strobe while still busy")
  `FBCL_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than a cycle")
  `FBCL_ASSERT_SAME(a_miss_not_pinned, out_valid && (out_status == STS_MISS), out_block_index != '0, "fill allocated the pinned entry")
  `FBCL_ASSERT_SAME(a_noblk_zero, out_valid && (out_status == STS_NOBLK), (out_block_index == '0) && (out_offset == '0), "no-block result with nonzero index or offset")

endmodule

>>> rtl/fbcl_ram.sv
// ---------------------------------------------------------------------------
// fbcl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module fbcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/fbcl_ctrl.sv
// ---------------------------------------------------------------------------
// fbcl_ctrl
// Sequencer: accept, scan the entry table, finish the last read, commit.
// ---------------------------------------------------------------------------
module fbcl_ctrl
  import fbcl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      // last read data is evaluated here
      ST_FINISH: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/fbcl_datapath.sv
// ---------------------------------------------------------------------------
// fbcl_datapath
// Entry table, scan accumulators, victim choice and result registers.
// ---------------------------------------------------------------------------
module fbcl_datapath
  import fbcl_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctl_cmd_t                      cmd,
  output dp_sts_t                       sts,
  input  logic [OP_W-1:0]               in_op,
  input  logic [FILE_W-1:0]             in_file_id,
  input  logic [ADDR_W-1:0]             in_address,
  input  logic [ADDR_W-1:0]             in_file_size,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  output logic                          out_valid,
  output logic [STATUS_W-1:0]           out_status,
  output logic [$clog2(NUM_BLOCKS)-1:0] out_block_index,
  output logic [OFFSET_W-1:0]           out_offset,
  output logic [ADDR_W-1:0]             out_fetch_address,
  output logic [FILL_W-1:0]             out_fill_length
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam logic [ADDR_W-1:0] OFS_MASK = ADDR_W'(BLOCK_BYTES - 1);

  // request
  op_t               op_r;
  logic [FILE_W-1:0] fid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [FILL_W-1:0] fill_r;
  logic              fid_ok_r;
  logic [CFG_W-1:0]  pinned_r;
  logic [AGE_W-1:0]  age_cnt_r;
  logic [NUM_BLOCKS-1:0] valid_r;

  // scan
  logic [IDX_W-1:0] idx_r;
  logic             ev_act_r;
  logic [IDX_W-1:0] ev_idx_r;
  entry_t           rd_entry;

  // accumulators
  logic                hit_found_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [OFFSET_W-1:0] hit_off_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic                oth_found_r;
  logic [IDX_W-1:0]    oth_idx_r;
  logic [AGE_W-1:0]    oth_age_r;
  logic                all_found_r;
  logic [IDX_W-1:0]    all_idx_r;
  logic [AGE_W-1:0]    all_age_r;

  // result
  logic                out_valid_r;
  status_t             out_status_r;
  logic [IDX_W-1:0]    out_blk_r;
  logic [OFFSET_W-1:0] out_off_r;
  logic [ADDR_W-1:0]   out_fetch_r;
  logic [FILL_W-1:0]   out_fill_r;

  // load-time fill length
  logic [ADDR_W-1:0] in_aligned;
  logic [ADDR_W-1:0] in_remain;
  logic [FILL_W-1:0] in_fill;
  logic              in_hit0;

  // evaluation of one read entry
  logic          ev_v;
  logic [ADDR_W:0] ev_diff;
  logic          ev_match;
  logic          ev_inval;

  // commit
  logic [ADDR_W-1:0] aligned;
  logic [IDX_W-1:0]  victim;
  logic              alloc;
  logic [AGE_W-1:0]  alloc_age;
  status_t           res_status;
  logic [IDX_W-1:0]  res_blk;
  logic [OFFSET_W-1:0] res_off;
  logic [ADDR_W-1:0] res_fetch;
  logic [FILL_W-1:0] res_fill;
  entry_t            wr_entry;

  assign sts.scan_last = (idx_r == IDX_W'(NUM_BLOCKS - 1));

  always_comb begin
    in_aligned = in_address & ~OFS_MASK;
    in_remain  = in_file_size - in_aligned;
    if (in_aligned >= in_file_size) begin
      in_fill = '0;
    end else if (in_remain >= ADDR_W'(BLOCK_BYTES)) begin
      in_fill = FILL_W'(BLOCK_BYTES);
    end else begin
      in_fill = in_remain[FILL_W-1:0];
    end
    // pinned entry zero: file 0, start 0, length from the register
    in_hit0 = (in_file_id == '0) && (pinned_r != '0) &&
              (in_address < ADDR_W'(pinned_r));
  end

  fbcl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_BLOCKS)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && alloc),
    .wr_addr (victim),
    .wr_data (wr_entry),
    .rd_addr (idx_r),
    .rd_data (rd_entry)
  );

  always_comb begin
    ev_v     = valid_r[ev_idx_r];
    ev_diff  = {1'b0, addr_r} - {1'b0, rd_entry.start};
    ev_match = ev_v && (rd_entry.length != '0) && (rd_entry.file == fid_r) &&
               !ev_diff[ADDR_W] && (ev_diff[ADDR_W-1:0] < ADDR_W'(rd_entry.length));
    ev_inval = (op_r == OP_INVAL) && fid_ok_r && ev_v && (rd_entry.file == fid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pinned_r <= PINNED_LENGTH_RST;
    end else if (cfg_wr_en) begin
      pinned_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_op);
      fid_r    <= in_file_id;
      addr_r   <= in_address;
      fill_r   <= in_fill;
      fid_ok_r <= (32'(in_file_id) < NUM_FILES);
      idx_r    <= IDX_W'(1);
    end else if (cmd.scan) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    ev_idx_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_act_r <= 1'b0;
    end else begin
      ev_act_r <= cmd.scan;
    end
  end

  // accumulators: ascending scan, strict compares keep the lower index on ties
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_found_r  <= in_hit0;
      hit_idx_r    <= '0;
      hit_off_r    <= in_address[OFFSET_W-1:0];
      free_found_r <= 1'b0;
      oth_found_r  <= 1'b0;
      all_found_r  <= 1'b0;
    end else if (ev_act_r) begin
      if (ev_match && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= ev_idx_r;
        hit_off_r   <= ev_diff[OFFSET_W-1:0];
      end
      if (!ev_v && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= ev_idx_r;
      end
      if (ev_v && (rd_entry.file != fid_r) &&
          (!oth_found_r || (rd_entry.age < oth_age_r))) begin
        oth_found_r <= 1'b1;
        oth_idx_r   <= ev_idx_r;
        oth_age_r   <= rd_entry.age;
      end
      if (ev_v && (!all_found_r || (rd_entry.age < all_age_r))) begin
        all_found_r <= 1'b1;
        all_idx_r   <= ev_idx_r;
        all_age_r   <= rd_entry.age;
      end
    end
  end

  always_comb begin
    aligned = addr_r & ~OFS_MASK;
    if (free_found_r) begin
      victim = free_idx_r;
    end else if (oth_found_r) begin
      victim = oth_idx_r;
    end else begin
      victim = all_idx_r;
    end

    alloc      = 1'b0;
    alloc_age  = '0;
    res_status = STS_DONE;
    res_blk    = '0;
    res_off    = '0;
    res_fetch  = '0;
    res_fill   = '0;
    case (op_r)
      OP_LOOKUP: begin
        res_status = STS_NOBLK;
        if (fid_ok_r) begin
          if (hit_found_r) begin
            // fill length is still reported on a hit
            res_status = STS_HIT;
            res_blk    = hit_idx_r;
            res_off    = hit_off_r;
            res_fill   = fill_r;
          end else begin
            res_fetch = aligned;
            if (fill_r != '0) begin
              alloc      = 1'b1;
              alloc_age  = age_cnt_r;
              res_status = STS_MISS;
              res_blk    = victim;
              res_off    = OFFSET_W'(addr_r & OFS_MASK);
              res_fill   = fill_r;
            end
          end
        end
      end
      OP_PRELOAD: begin
        if (fid_ok_r) begin
          res_fetch = aligned;
          res_off   = OFFSET_W'(addr_r & OFS_MASK);
          res_fill  = fill_r;
          if (fill_r != '0) begin
            alloc   = 1'b1;
            res_blk = victim;
          end
        end
      end
      default: begin
        res_status = STS_DONE;
      end
    endcase

    wr_entry.file   = fid_r;
    wr_entry.start  = aligned;
    wr_entry.length = fill_r;
    wr_entry.age    = alloc_age;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= NUM_BLOCKS'(1);
      age_cnt_r <= AGE_RST;
    end else begin
      if (ev_act_r && ev_inval) begin
        valid_r[ev_idx_r] <= 1'b0;
      end
      if (cmd.commit && alloc) begin
        valid_r[victim] <= 1'b1;
        if (op_r == OP_LOOKUP) begin
          age_cnt_r <= age_cnt_r + AGE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_blk_r    <= res_blk;
      out_off_r    <= res_off;
      out_fetch_r  <= res_fetch;
      out_fill_r   <= res_fill;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_index   = out_blk_r;
  assign out_offset        = out_off_r;
  assign out_fetch_address = out_fetch_r;
  assign out_fill_length   = out_fill_r;

endmodule

>>> dv/file_block_cache_lookup_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// file_block_cache_lookup_checker
// Watches the item, result and register ports of the file block cache.
// Keeps its own copy of the entry table and pinned length, and computes the
// reply of each accepted item. Each reply strobe is compared field by field
// with the oldest computed reply. Exports the error and outstanding counts.
// ---------------------------------------------------------------------------
module file_block_cache_lookup_checker
  import fbcl_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [OP_W-1:0]               in_op,
  input  logic [FILE_W-1:0]             in_file_id,
  input  logic [ADDR_W-1:0]             in_address,
  input  logic [ADDR_W-1:0]             in_file_size,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  input  logic                          out_valid,
  input  logic [STATUS_W-1:0]           out_status,
  input  logic [$clog2(NUM_BLOCKS)-1:0] out_block_index,
  input  logic [OFFSET_W-1:0]           out_offset,
  input  logic [ADDR_W-1:0]             out_fetch_address,
  input  logic [FILL_W-1:0]             out_fill_length,
  output int                            fail_count,
  output int                            pending
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    blk;
    logic [OFFSET_W-1:0] off;
    logic [ADDR_W-1:0]   fetch;
    logic [FILL_W-1:0]   fill;
  } cache_reply_t;

  logic              line_valid [NUM_BLOCKS];
  logic [FILE_W-1:0] line_file  [NUM_BLOCKS];
  logic [31:0]       line_start [NUM_BLOCKS];
  logic [31:0]       line_len   [NUM_BLOCKS];
  logic [AGE_W-1:0]  line_age   [NUM_BLOCKS];
  logic [AGE_W-1:0]  fill_stamp;
  logic [CFG_W-1:0]  pinned_len;

  cache_reply_t reply_q[$];
  int           err_total;

  initial begin
    err_total  = 0;
    fail_count = 0;
    pending    = 0;
  end

  function automatic void clear_table();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      line_valid[i] = (i == 0);
      line_file[i]  = '0;
      line_start[i] = '0;
      line_len[i]   = '0;
      line_age[i]   = '0;
    end
    fill_stamp = AGE_RST;
    pinned_len = PINNED_LENGTH_RST;
  endfunction

  // free line first, else oldest of another file, else oldest overall
  function automatic int pick_victim(logic [FILE_W-1:0] fid);
    int               best;
    logic             found;
    logic [AGE_W-1:0] best_age;
    best     = 1;
    found    = 1'b0;
    best_age = '0;
    for (int i = 1; i < NUM_BLOCKS; i++)
      if (!line_valid[i]) return i;
    for (int i = 1; i < NUM_BLOCKS; i++)
      if (line_file[i] != fid && (!found || line_age[i] < best_age)) begin
        found    = 1'b1;
        best     = i;
        best_age = line_age[i];
      end
    if (found) return best;
    for (int i = 1; i < NUM_BLOCKS; i++)
      if (!found || line_age[i] < best_age) begin
        found    = 1'b1;
        best     = i;
        best_age = line_age[i];
      end
    return best;
  endfunction

  function automatic void install(int idx, logic [FILE_W-1:0] fid, logic [31:0] base,
                                  logic [31:0] len, logic [AGE_W-1:0] age);
    line_valid[idx] = 1'b1;
    line_file[idx]  = fid;
    line_start[idx] = base;
    line_len[idx]   = len;
    line_age[idx]   = age;
  endfunction

  function automatic cache_reply_t resolve_access(logic [OP_W-1:0] op, logic [FILE_W-1:0] fid,
                                                  logic [ADDR_W-1:0] addr,
                                                  logic [ADDR_W-1:0] fsize);
    cache_reply_t r;
    op_t          cmd;
    logic [31:0]  addr32, fsize32, aligned, fill, len;
    int           hit, victim;
    cmd     = op_t'(op);
    addr32  = {1'b0, addr};
    fsize32 = {1'b0, fsize};
    aligned = addr32 - (addr32 % 32'(BLOCK_BYTES));
    fill    = '0;
    if (aligned < fsize32)
      fill = (fsize32 - aligned < 32'(BLOCK_BYTES)) ? fsize32 - aligned : 32'(BLOCK_BYTES);
    r        = '0;
    r.status = STS_DONE;
    case (cmd)
      OP_LOOKUP: begin
        r.status = STS_NOBLK;
        if (int'(fid) < NUM_FILES) begin
          hit = -1;
          for (int i = 0; i < NUM_BLOCKS; i++) begin
            len = (i == 0) ? {16'd0, pinned_len} : line_len[i];
            if (hit < 0 && line_valid[i] && len != 0 && line_file[i] == fid &&
                addr32 >= line_start[i] && addr32 < line_start[i] + len)
              hit = i;
          end
          r.fill = FILL_W'(fill);
          if (hit >= 0) begin
            r.status = STS_HIT;
            r.blk    = IDX_W'(hit);
            r.off    = OFFSET_W'(addr32 - line_start[hit]);
          end else begin
            r.fetch = ADDR_W'(aligned);
            if (fill != 0) begin
              victim = pick_victim(fid);
              install(victim, fid, aligned, fill, fill_stamp);
              fill_stamp = fill_stamp + 1'b1;
              r.status   = STS_MISS;
              r.blk      = IDX_W'(victim);
              r.off      = OFFSET_W'(addr32 - aligned);
            end
          end
        end
      end
      OP_PRELOAD: begin
        if (int'(fid) < NUM_FILES) begin
          r.fetch = ADDR_W'(aligned);
          r.off   = OFFSET_W'(addr32 - aligned);
          r.fill  = FILL_W'(fill);
          // preloaded lines are stamped oldest
          if (fill != 0) begin
            victim = pick_victim(fid);
            install(victim, fid, aligned, fill, '0);
            r.blk = IDX_W'(victim);
          end
        end
      end
      OP_INVAL: begin
        if (int'(fid) < NUM_FILES)
          for (int i = 1; i < NUM_BLOCKS; i++)
            if (line_valid[i] && line_file[i] == fid) begin
              line_valid[i] = 1'b0;
              install(i, '0, '0, '0, '0);
              line_valid[i] = 1'b0;
            end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      err_total++;
    end
  endfunction

  always @(posedge clk) begin
    cache_reply_t want, got;
    if (!rst_n) begin
      clear_table();
      reply_q.delete();
    end else begin
      if (out_valid) begin
        got.status = out_status;
        got.blk    = out_block_index;
        got.off    = out_offset;
        got.fetch  = out_fetch_address;
        got.fill   = out_fill_length;
        if (reply_q.size() == 0) begin
          $display("%0t: reply with no item outstanding, status 0x%0h", $time, got.status);
          err_total++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("block_index", 32'(want.blk), 32'(got.blk));
          check_field("offset", 32'(want.off), 32'(got.off));
          check_field("fetch_address", 32'(want.fetch), 32'(got.fetch));
          check_field("fill_length", 32'(want.fill), 32'(got.fill));
        end
      end
      if (start && !busy)
        reply_q.push_back(resolve_access(in_op, in_file_id, in_address, in_file_size));
      if (cfg_wr_en)
        pinned_len = cfg_wr_data;
    end
    fail_count <= err_total;
    pending    <= reply_q.size();
  end

endmodule

>>> dv/file_block_cache_lookup_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// file_block_cache_lookup_test
// Stimulus and verdict for the file block cache lookup.
// Runs a short directed sequence, then random lookups, preloads, invalidates
// and no-ops over a narrow block window so lines hit and get evicted,
// across several pinned length settings. Checking is in the checker module.
// ---------------------------------------------------------------------------
module file_block_cache_lookup_test;
  import fbcl_pkg::*;

  localparam int IDX_W         = $clog2(NUM_BLOCKS_DEF);
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEMS_PER_SET = 310;
  localparam int CHUNK         = 40;
  localparam int SETTLE_CYCLES = 24;
  localparam int NUM_SETS      = 5;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_op;
  logic [FILE_W-1:0]   in_file_id;
  logic [ADDR_W-1:0]   in_address;
  logic [ADDR_W-1:0]   in_file_size;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [IDX_W-1:0]    out_block_index;
  logic [OFFSET_W-1:0] out_offset;
  logic [ADDR_W-1:0]   out_fetch_address;
  logic [FILL_W-1:0]   out_fill_length;
  int                  fail_count;
  int                  pending;
  int                  cycles;

  file_block_cache_lookup uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_file_id       (in_file_id),
    .in_address       (in_address),
    .in_file_size     (in_file_size),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_block_index  (out_block_index),
    .out_offset       (out_offset),
    .out_fetch_address(out_fetch_address),
    .out_fill_length  (out_fill_length)
  );

  file_block_cache_lookup_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_file_id       (in_file_id),
    .in_address       (in_address),
    .in_file_size     (in_file_size),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_block_index  (out_block_index),
    .out_offset       (out_offset),
    .out_fetch_address(out_fetch_address),
    .out_fill_length  (out_fill_length),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // item is taken at the first edge with busy low; start stays up afterwards
  task automatic send_item(op_t op, logic [FILE_W-1:0] fid, logic [ADDR_W-1:0] addr,
                           logic [ADDR_W-1:0] fsize, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_file_id   <= fid;
    in_address   <= addr;
    in_file_size <= fsize;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
  endtask

  task automatic write_pinned(logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly a narrow window of blocks so lines get hit, refilled and evicted
  task automatic send_random(int gap, logic focus, logic [FILE_W-1:0] focus_fid);
    int                sel;
    int                blkno;
    op_t               op;
    logic [FILE_W-1:0] fid;
    logic [ADDR_W-1:0] addr, fsize;
    sel   = $urandom_range(0, 99);
    blkno = $urandom_range(0, 23);
    fid   = focus ? focus_fid : FILE_W'($urandom_range(0, NUM_FILES - 1));
    addr  = ADDR_W'(blkno * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
    if ($urandom_range(0, 9) < 7)
      fsize = ADDR_W'($urandom_range(24 * BLOCK_BYTES, 1 << 20));
    else
      fsize = ADDR_W'(blkno * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES));
    if (sel < 12) begin
      addr  = ADDR_W'($urandom());
      fsize = ADDR_W'($urandom());
    end
    sel = $urandom_range(0, 99);
    if (sel < 70)      op = OP_LOOKUP;
    else if (sel < 85) op = OP_PRELOAD;
    else if (sel < 93) op = OP_INVAL;
    else               op = OP_NOP;
    send_item(op, fid, addr, fsize, gap);
  endtask

  initial begin
    logic [CFG_W-1:0]  pin_set [NUM_SETS];
    logic              burst, focus;
    logic [FILE_W-1:0] focus_fid;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_op        <= OP_LOOKUP;
    in_file_id   <= '0;
    in_address   <= '0;
    in_file_size <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    pin_set[0] = PINNED_LENGTH_RST;
    pin_set[1] = '0;
    pin_set[2] = '1;
    pin_set[3] = CFG_W'($urandom());
    pin_set[4] = CFG_W'(1);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int s = 0; s < NUM_SETS; s++) begin
      write_pinned(pin_set[s]);
      if (s == 0) begin
        send_item(OP_LOOKUP, 3'd0, 31'd0, 31'h7FFFFFFF, 0);      // pinned start
        send_item(OP_LOOKUP, 3'd0, 31'd4607, 31'd100000, 1);     // last pinned byte
        send_item(OP_LOOKUP, 3'd0, 31'd4608, 31'd10000, 0);      // just past pinned
        send_item(OP_LOOKUP, 3'd0, 31'd4100, 31'd10000, 2);      // overlap, low index
        send_item(OP_LOOKUP, 3'd0, 31'd8191, 31'd10000, 0);
        send_item(OP_LOOKUP, 3'd3, 31'h7FFFFFFF, 31'h7FFFFFFF, 5); // top of range
        send_item(OP_LOOKUP, 3'd3, 31'd0, 31'd0, 0);             // empty file
        send_item(OP_LOOKUP, 3'd5, 31'd20000, 31'd20000, 3);     // short tail
        send_item(OP_LOOKUP, 3'd5, 31'd20480, 31'd20480, 0);     // past end
        send_item(OP_PRELOAD, 3'd7, 31'd12345, 31'd100000, 0);
        send_item(OP_PRELOAD, 3'd7, 31'd5000, 31'd0, 4);         // preload nothing
        send_item(OP_LOOKUP, 3'd7, 31'd12345, 31'd100000, 0);    // preloaded hit
        send_item(OP_INVAL, 3'd7, 31'h7FFFFFFF, 31'h7FFFFFFF, 0);
        send_item(OP_LOOKUP, 3'd7, 31'd12345, 31'd100000, 1);    // refetch after free
        send_item(OP_NOP, 3'd6, 31'h55555555, 31'h2AAAAAAA, 0);
        send_item(OP_INVAL, 3'd0, 31'd0, 31'd0, 0);              // entry zero survives
        send_item(OP_LOOKUP, 3'd0, 31'd1, 31'd4, 2);
        send_item(OP_PRELOAD, 3'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 0);
      end else begin
        send_item(OP_LOOKUP, 3'd0, 31'd0, 31'h7FFFFFFF, 0);
        send_item(OP_LOOKUP, 3'd0, ADDR_W'(pin_set[s] - 1'b1), 31'h7FFFFFFF, 0);
        send_item(OP_LOOKUP, 3'd0, ADDR_W'(pin_set[s]), 31'h7FFFFFFF, 1);
      end
      burst     = 1'b0;
      focus     = 1'b0;
      focus_fid = '0;
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if (n % CHUNK == 0) begin
          burst     = ($urandom_range(0, 3) == 0);
          focus     = ($urandom_range(0, 3) == 0);
          focus_fid = FILE_W'($urandom_range(0, NUM_FILES - 1));
        end
        send_random(burst ? 0 : $urandom_range(0, 5), focus, focus_fid);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
